>>> rtl/cht_pkg.sv
package cht_pkg;

  // Operation codes carried in the opcode field.
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DUP      = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_MULT1 = 3'd0;
  localparam logic [2:0] REG_ADD1  = 3'd1;
  localparam logic [2:0] REG_MULT2 = 3'd2;
  localparam logic [2:0] REG_ADD2  = 3'd3;
  localparam logic [2:0] REG_PRIME = 3'd4;
  localparam logic [2:0] REG_SIZE  = 3'd5;

  // Reset values of the configuration registers.
  localparam logic [63:0] RST_MULT  = 64'd1;
  localparam logic [63:0] RST_ADD   = 64'd0;
  localparam logic [63:0] RST_PRIME = 64'd2305843009213693951;
  localparam logic [3:0]  RST_SIZE  = 4'd3;
  localparam logic [4:0]  MIN_SIZE  = 5'd3;

  // Number of one-bit steps in the modulo unit.
  localparam logic [6:0] DIV_STEPS = 7'd64;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] lookup_key;
    logic [31:0]        entry_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        result_value;
    logic signed [31:0] displaced_key;
  } out_item_t;

  // One slot of a way: occupied flag, key and value.
  typedef struct packed {
    logic        busy;
    logic [31:0] key;
    logic [31:0] value;
  } slot_t;

  // Which hash the controller asks for.
  typedef enum logic [1:0] {
    HSEL_WAY1 = 2'd0,
    HSEL_WAY2 = 2'd1,
    HSEL_KICK = 2'd2
  } hash_sel_t;

  typedef struct packed {
    logic      clear_step;
    logic      accept;
    logic      hash_start;
    hash_sel_t hash_sel;
    logic      mem_read;
    logic      decide;
    logic      kick_step;
    logic      out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic hash_done;
    logic need_kick;
    logic kick_end;
    logic out_free;
  } dp_status_t;

endpackage

>>> rtl/cht_hash.sv
module cht_hash #(
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          key,
  input  logic [63:0]          mult,
  input  logic [63:0]          add,
  input  logic [63:0]          prime,
  input  logic [ADDR_BITS-1:0] mask,
  output logic                 busy,
  output logic                 done,
  output logic [ADDR_BITS-1:0] index
);
  import cht_pkg::*;

  typedef enum logic [4:0] {
    H_IDLE = 5'b00001,
    H_MLO  = 5'b00010,
    H_MHI  = 5'b00100,
    H_SUM  = 5'b01000,
    H_DIV  = 5'b10000
  } hstate_t;

  hstate_t              state;
  logic [31:0]          key_q;
  logic [63:0]          mult_q;
  logic [63:0]          add_q;
  logic [63:0]          prime_q;
  logic [ADDR_BITS-1:0] mask_q;
  logic [63:0]          prod_lo;
  logic [31:0]          prod_hi;
  logic [63:0]          rem;
  logic [63:0]          dq;
  logic [6:0]           cnt;

  logic [31:0] mul_op;
  logic [63:0] prod_w;
  logic [63:0] sum_w;
  logic [64:0] trial;
  logic [64:0] diff;
  logic [63:0] rem_next;

  // One shared 32x32 multiplier: low half of a first, then high half.
  assign mul_op = (state == H_MLO) ? mult_q[31:0] : mult_q[63:32];
  assign prod_w = mul_op * key_q;
  assign sum_w  = prod_lo + {prod_hi, 32'd0} + add_q;

  // Restoring remainder step, one dividend bit per cycle.
  assign trial    = {rem, dq[63]};
  assign diff     = trial - {1'b0, prime_q};
  assign rem_next = (trial >= {1'b0, prime_q}) ? diff[63:0] : trial[63:0];

  assign busy = (state != H_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      done  <= 1'b0;
    end else begin
      case (state)
        H_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= H_MLO;
          end
        end
        H_MLO: begin
          done  <= 1'b0;
          state <= H_MHI;
        end
        H_MHI: begin
          done  <= 1'b0;
          state <= H_SUM;
        end
        H_SUM: begin
          if (prime_q == 64'd0) begin
            state <= H_IDLE;
            done  <= 1'b1;
          end else begin
            state <= H_DIV;
            done  <= 1'b0;
          end
        end
        H_DIV: begin
          if (cnt == 7'd1) begin
            state <= H_IDLE;
            done  <= 1'b1;
          end else begin
            done  <= 1'b0;
          end
        end
        default: begin
          state <= H_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  // Operand capture, partial products and the remainder registers.
  always_ff @(posedge clk) begin
    if (state == H_IDLE && start) begin
      key_q   <= key;
      mult_q  <= mult;
      add_q   <= add;
      prime_q <= prime;
      mask_q  <= mask;
    end
    if (state == H_MLO) begin
      prod_lo <= prod_w;
    end
    if (state == H_MHI) begin
      prod_hi <= prod_w[31:0];
    end
    if (state == H_SUM) begin
      rem   <= 64'd0;
      dq    <= sum_w;
      cnt   <= DIV_STEPS;
      index <= sum_w[ADDR_BITS-1:0] & mask_q;
    end
    if (state == H_DIV) begin
      rem   <= rem_next;
      dq    <= {dq[62:0], 1'b0};
      cnt   <= cnt - 7'd1;
      index <= rem_next[ADDR_BITS-1:0] & mask_q;
    end
  end

`ifndef NO_ASSERTIONS
  // Completion is a single-cycle pulse.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("hash done held for more than one cycle");
  // Completion always leaves the unit idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("hash done while still busy");
`endif

endmodule

>>> rtl/cht_datapath.sv
module cht_datapath #(
  parameter int ADDR_BITS = 10,
  parameter int MAX_KICKS = 50
) (
  input  logic                clk,
  input  logic                rst,
  input  cht_pkg::dp_cmd_t    cmd,
  output cht_pkg::dp_status_t stat,
  input  cht_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cht_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [63:0]         cfg_data
);
  import cht_pkg::*;

  localparam int DEPTH  = 1 << ADDR_BITS;
  localparam int KBITS  = $clog2(MAX_KICKS + 1);

  // Configuration registers.
  logic [63:0] mult1, add1, mult2, add2, prime;
  logic [3:0]  size_log2;

  // Operation and eviction registers.
  logic [1:0]           op;
  logic [31:0]          ck;
  logic [31:0]          cv;
  logic                 kway;
  logic [KBITS-1:0]     kicks;
  logic [ADDR_BITS-1:0] idx1, idx2;
  logic                 hway;
  logic [ADDR_BITS:0]   clr_cnt;
  logic [1:0]           res_status;
  logic [31:0]          res_value;
  logic [31:0]          res_key;

  // Way storage with registered read data.
  slot_t mem1 [DEPTH];
  slot_t mem2 [DEPTH];
  slot_t rd1, rd2;

  logic                 we1, we2;
  logic [ADDR_BITS-1:0] wa1, wa2;
  slot_t                wd1, wd2;

  logic                 hash_way;
  logic                 hash_busy, hash_done;
  logic [ADDR_BITS-1:0] hash_idx;
  logic [ADDR_BITS-1:0] mask;
  logic [4:0]           sz;
  logic                 hit1, hit2;
  slot_t                krd;
  slot_t                new_slot;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mult1     <= RST_MULT;
      add1      <= RST_ADD;
      mult2     <= RST_MULT;
      add2      <= RST_ADD;
      prime     <= RST_PRIME;
      size_log2 <= RST_SIZE;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MULT1: mult1 <= cfg_data;
        REG_ADD1:  add1 <= cfg_data;
        REG_MULT2: mult2 <= cfg_data;
        REG_ADD2:  add2 <= cfg_data;
        REG_PRIME: prime <= cfg_data;
        REG_SIZE:  size_log2 <= cfg_data[3:0];
        default: begin
        end
      endcase
    end
  end

  // Table size clamped to the range the memory supports.
  always_comb begin
    if ({1'b0, size_log2} < MIN_SIZE) begin
      sz = MIN_SIZE;
    end else if ({1'b0, size_log2} > 5'(ADDR_BITS)) begin
      sz = 5'(ADDR_BITS);
    end else begin
      sz = {1'b0, size_log2};
    end
    for (int i = 0; i < ADDR_BITS; i++) begin
      mask[i] = (5'(i) < sz);
    end
  end

  // Hash unit, always fed with the current key.
  always_comb begin
    case (cmd.hash_sel)
      HSEL_WAY1: hash_way = 1'b0;
      HSEL_WAY2: hash_way = 1'b1;
      HSEL_KICK: hash_way = kway;
      default:   hash_way = 1'b0;
    endcase
  end

  cht_hash #(.ADDR_BITS(ADDR_BITS)) u_hash (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.hash_start),
    .key   (ck),
    .mult  (hash_way ? mult2 : mult1),
    .add   (hash_way ? add2 : add1),
    .prime (prime),
    .mask  (mask),
    .busy  (hash_busy),
    .done  (hash_done),
    .index (hash_idx)
  );

  // Match and eviction views of the read data.
  assign hit1     = rd1.busy && (rd1.key == ck);
  assign hit2     = rd2.busy && (rd2.key == ck);
  assign krd      = kway ? rd2 : rd1;
  assign new_slot = '{busy: 1'b1, key: ck, value: cv};

  // Write port selection for both ways.
  always_comb begin
    we1 = 1'b0;
    we2 = 1'b0;
    wa1 = idx1;
    wa2 = idx2;
    wd1 = new_slot;
    wd2 = new_slot;
    if (cmd.clear_step) begin
      we1 = 1'b1;
      we2 = 1'b1;
      wa1 = clr_cnt[ADDR_BITS-1:0];
      wa2 = clr_cnt[ADDR_BITS-1:0];
      wd1 = '0;
      wd2 = '0;
    end else if (cmd.decide) begin
      if (op == OP_INSERT && !hit1 && !hit2) begin
        we1 = !rd1.busy;
        we2 = rd1.busy && !rd2.busy;
      end else if (op == OP_DELETE) begin
        we1 = hit1;
        we2 = !hit1 && hit2;
        wd1 = '{busy: 1'b0, key: rd1.key, value: rd1.value};
        wd2 = '{busy: 1'b0, key: rd2.key, value: rd2.value};
      end
    end else if (cmd.kick_step) begin
      we1 = !kway;
      we2 = kway;
    end
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wa1] <= wd1;
    end
    if (we2) begin
      mem2[wa2] <= wd2;
    end
    if (cmd.mem_read) begin
      rd1 <= mem1[idx1];
      rd2 <= mem2[idx2];
    end
  end

  // Clearing pass over both ways after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Operation, index and result registers.
  always_ff @(posedge clk) begin
    if (cmd.hash_start) begin
      hway <= hash_way;
    end
    if (hash_done) begin
      if (hway) begin
        idx2 <= hash_idx;
      end else begin
        idx1 <= hash_idx;
      end
    end
    if (cmd.accept) begin
      op    <= in_data.opcode;
      ck    <= in_data.lookup_key;
      cv    <= in_data.entry_value;
      kway  <= 1'b0;
      kicks <= '0;
    end
    if (cmd.decide) begin
      res_key <= 32'd0;
      case (op)
        OP_INSERT: begin
          res_status <= (hit1 || hit2) ? ST_DUP : ST_OK;
          res_value  <= 32'd0;
        end
        OP_LOOKUP: begin
          res_status <= (hit1 || hit2) ? ST_OK : ST_NOTFOUND;
          res_value  <= hit1 ? rd1.value : (hit2 ? rd2.value : 32'd0);
        end
        OP_DELETE: begin
          res_status <= (hit1 || hit2) ? ST_OK : ST_NOTFOUND;
          res_value  <= 32'd0;
        end
        default: begin
          res_status <= ST_NOTFOUND;
          res_value  <= 32'd0;
        end
      endcase
    end
    if (cmd.kick_step) begin
      if (!krd.busy) begin
        res_status <= ST_OK;
        res_value  <= 32'd0;
        res_key    <= 32'd0;
      end else begin
        ck         <= krd.key;
        cv         <= krd.value;
        kway       <= !kway;
        kicks      <= kicks + 1'b1;
        res_status <= ST_FULL;
        res_value  <= krd.value;
        res_key    <= krd.key;
      end
    end
  end

  // Output register toward the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.status        <= res_status;
      out_data.result_value  <= res_value;
      out_data.displaced_key <= res_key;
    end
  end

  // Status back to the controller.
  assign stat.clear_done = (clr_cnt == (ADDR_BITS + 1)'(DEPTH));
  assign stat.hash_done  = hash_done;
  assign stat.need_kick  = (op == OP_INSERT) && !hit1 && !hit2 && rd1.busy && rd2.busy;
  assign stat.kick_end   = !krd.busy || (kicks == KBITS'(MAX_KICKS - 1));
  assign stat.out_free   = !out_valid || !out_stall;

`ifndef NO_ASSERTIONS
  // A result is never loaded over one still waiting for the consumer.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over a pending result");
  // The hash unit is never restarted while it works.
  a_hash_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.hash_start |-> !hash_busy)
    else $error("hash started while busy");
  // Once the clearing pass ends it stays ended.
  a_clear_hold: assert property (@(posedge clk) disable iff (rst)
    stat.clear_done |=> stat.clear_done)
    else $error("clearing pass restarted");
`endif

endmodule

>>> rtl/cht_ctrl.sv
module cht_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output cht_pkg::dp_cmd_t    cmd,
  input  cht_pkg::dp_status_t stat
);
  import cht_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_HASH1  = 13'b0000000000100,
    S_WAIT1  = 13'b0000000001000,
    S_HASH2  = 13'b0000000010000,
    S_WAIT2  = 13'b0000000100000,
    S_READ   = 13'b0000001000000,
    S_DECIDE = 13'b0000010000000,
    S_KHASH  = 13'b0000100000000,
    S_KWAIT  = 13'b0001000000000,
    S_KREAD  = 13'b0010000000000,
    S_KSTEP  = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  state_t state, state_next;

  assign in_stall = (state != S_IDLE);

  // Next state and commands to the datapath.
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.hash_sel = HSEL_WAY1;
    case (state)
      S_CLEAR: begin
        if (stat.clear_done) begin
          state_next = S_IDLE;
        end else begin
          cmd.clear_step = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_HASH1;
        end
      end
      S_HASH1: begin
        cmd.hash_start = 1'b1;
        state_next     = S_WAIT1;
      end
      S_WAIT1: begin
        if (stat.hash_done) begin
          state_next = S_HASH2;
        end
      end
      S_HASH2: begin
        cmd.hash_start = 1'b1;
        cmd.hash_sel   = HSEL_WAY2;
        state_next     = S_WAIT2;
      end
      S_WAIT2: begin
        if (stat.hash_done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.mem_read = 1'b1;
        state_next   = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = stat.need_kick ? S_KHASH : S_DONE;
      end
      S_KHASH: begin
        cmd.hash_start = 1'b1;
        cmd.hash_sel   = HSEL_KICK;
        state_next     = S_KWAIT;
      end
      S_KWAIT: begin
        if (stat.hash_done) begin
          state_next = S_KREAD;
        end
      end
      S_KREAD: begin
        cmd.mem_read = 1'b1;
        state_next   = S_KSTEP;
      end
      S_KSTEP: begin
        cmd.kick_step = 1'b1;
        state_next    = stat.kick_end ? S_DONE : S_KHASH;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted transaction always starts with the first-way hash.
  a_accept_hash: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_HASH1))
    else $error("accepted transaction did not start hashing");
  // No transaction is taken during the clearing pass.
  a_clear_stall: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("input accepted during clearing pass");
`endif

endmodule

>>> rtl/cuckoo_hash_table_unit.sv
// Channel  Handshake            Payload
// in       in_valid / in_stall  in_data   (opcode, lookup_key, entry_value)
// out      out_valid / out_stall out_data (status, result_value, displaced_key)
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each hash takes two 32x32 partial products, a sum, and 64 steps of the
// one-bit remainder unit (no steps when the modulus is zero). An operation
// takes two hashes, a read and a decision; each eviction adds one hash, a
// read and an eviction step. After reset a clearing pass over all 2^ADDR_BITS
// slots empties both ways before the first transaction is taken. A finished
// result waits in the output register while the next transaction is taken and worked on.
module cuckoo_hash_table_unit #(
  parameter int ADDR_BITS = 10,
  parameter int MAX_KICKS = 50
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cht_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cht_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import cht_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t stat;

  cht_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  cht_datapath #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_KICKS (MAX_KICKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cht_pkg::*;

  localparam int ADDR_BITS = 10;
  localparam int MAX_KICKS = 50;
  localparam int SLOTS = 1 << ADDR_BITS;
  localparam longint CYCLE_LIMIT = 20000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Predicts the hash table contents and holds the results still owed by the block.
  class table_scoreboard;
    bit [63:0] mult1, add1, mult2, add2, prime;
    bit [3:0]  size_reg;
    bit        busy1 [SLOTS];
    bit [31:0] keys1 [SLOTS];
    bit [31:0] vals1 [SLOTS];
    bit        busy2 [SLOTS];
    bit [31:0] keys2 [SLOTS];
    bit [31:0] vals2 [SLOTS];
    out_item_t owed_results[$];
    int        mismatches;

    function void clear();
      mult1 = RST_MULT;
      add1 = RST_ADD;
      mult2 = RST_MULT;
      add2 = RST_ADD;
      prime = RST_PRIME;
      size_reg = RST_SIZE;
      mismatches = 0;
      foreach (busy1[i]) begin
        busy1[i] = 0;
        busy2[i] = 0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      case (idx)
        REG_MULT1: mult1 = data;
        REG_ADD1:  add1 = data;
        REG_MULT2: mult2 = data;
        REG_ADD2:  add2 = data;
        REG_PRIME: prime = data;
        REG_SIZE:  size_reg = data[3:0];
        default: ;
      endcase
    endfunction

    // Universal hash of one way, reduced to the slots in use.
    function int unsigned slot_index(bit [31:0] key, bit [63:0] mult, bit [63:0] add);
      bit [63:0] h;
      int unsigned sz;
      h = mult * {32'd0, key} + add;
      if (prime != 0) h = h % prime;
      sz = size_reg;
      if (sz < 3) sz = 3;
      if (sz > ADDR_BITS) sz = ADDR_BITS;
      return int'(h & ((64'd1 << sz) - 1));
    endfunction

    // Applies one transaction to the table and queues the result it must give.
    function void note_input(in_item_t it);
      out_item_t r;
      bit [31:0] key, cur_k, cur_v, tmp_k, tmp_v;
      int unsigned i1, i2, s;
      bit hit1, hit2, on_way1, placed;
      key = it.lookup_key;
      i1 = slot_index(key, mult1, add1);
      i2 = slot_index(key, mult2, add2);
      hit1 = busy1[i1] && keys1[i1] == key;
      hit2 = busy2[i2] && keys2[i2] == key;
      r = '0;
      r.status = ST_NOTFOUND;
      case (it.opcode)
        OP_INSERT: begin
          if (hit1 || hit2) begin
            r.status = ST_DUP;
          end else if (!busy1[i1]) begin
            busy1[i1] = 1; keys1[i1] = key; vals1[i1] = it.entry_value;
            r.status = ST_OK;
          end else if (!busy2[i2]) begin
            busy2[i2] = 1; keys2[i2] = key; vals2[i2] = it.entry_value;
            r.status = ST_OK;
          end else begin
            // Evict residents, alternating ways, until a slot frees up or kicks run out.
            cur_k = key;
            cur_v = it.entry_value;
            on_way1 = 1;
            placed = 0;
            for (int n = 0; n < MAX_KICKS && !placed; n++) begin
              if (on_way1) begin
                s = slot_index(cur_k, mult1, add1);
                if (!busy1[s]) begin
                  busy1[s] = 1; keys1[s] = cur_k; vals1[s] = cur_v;
                  placed = 1;
                end else begin
                  tmp_k = keys1[s]; tmp_v = vals1[s];
                  keys1[s] = cur_k; vals1[s] = cur_v;
                end
              end else begin
                s = slot_index(cur_k, mult2, add2);
                if (!busy2[s]) begin
                  busy2[s] = 1; keys2[s] = cur_k; vals2[s] = cur_v;
                  placed = 1;
                end else begin
                  tmp_k = keys2[s]; tmp_v = vals2[s];
                  keys2[s] = cur_k; vals2[s] = cur_v;
                end
              end
              if (!placed) begin
                cur_k = tmp_k;
                cur_v = tmp_v;
                on_way1 = !on_way1;
              end
            end
            if (placed) begin
              r.status = ST_OK;
            end else begin
              r.status = ST_FULL;
              r.displaced_key = cur_k;
              r.result_value = cur_v;
            end
          end
        end
        OP_LOOKUP: begin
          if (hit1) begin
            r.status = ST_OK; r.result_value = vals1[i1];
          end else if (hit2) begin
            r.status = ST_OK; r.result_value = vals2[i2];
          end
        end
        OP_DELETE: begin
          if (hit1) begin
            busy1[i1] = 0; r.status = ST_OK;
          end else if (hit2) begin
            busy2[i2] = 0; r.status = ST_OK;
          end
        end
        default: ;
      endcase
      owed_results.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction: status %0d value %h key %h",
                   got.status, got.result_value, got.displaced_key);
        return;
      end
      want = owed_results.pop_front();
      if (got.status !== want.status || got.result_value !== want.result_value ||
          got.displaced_key !== want.displaced_key) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result mismatch: expected status %0d value %h key %h, got %0d %h %h",
                   want.status, want.result_value, want.displaced_key,
                   got.status, got.result_value, got.displaced_key);
      end
    endfunction
  endclass

  logic       clk = 0;
  logic       rst = 1;
  logic       in_valid = 0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 0;
  out_item_t  out_data;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  table_scoreboard sb;
  bit          idle_on = 1;
  bit          hold_req = 0;
  longint      cycles = 0;
  bit [31:0]   key_pool[$];

  cuckoo_hash_table_unit #(.ADDR_BITS(ADDR_BITS), .MAX_KICKS(MAX_KICKS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Result side: random stalls, one long hold-off on request, and checking.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = 3000;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_stall = 1;
        hold_left--;
      end else begin
        out_stall = idle_on && ($urandom_range(99) < 13);
      end
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Offers one operation and waits until the block takes it.
  task automatic send_op(logic [1:0] op, logic [31:0] key, logic [31:0] value);
    in_item_t it;
    it.opcode = op;
    it.lookup_key = key;
    it.entry_value = value;
    @(negedge clk);
    while (idle_on && $urandom_range(99) < 13) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [63:0] data);
    @(negedge clk);
    cfg_valid = 1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Lets every owed result come back before the table is reconfigured.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 0;
    while (sb.owed_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic fill_pool(int n);
    key_pool.delete();
    for (int i = 0; i < n; i++) key_pool.push_back($urandom);
  endtask

  // Random operations: mostly keys from a small pool so that hits, evictions
  // and full tables are common, the rest fully random keys.
  task automatic random_ops(int n, int hold_at);
    logic [1:0] op;
    logic [31:0] key;
    int r;
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_req = 1;
      r = $urandom_range(99);
      if (r < 45) op = OP_INSERT;
      else if (r < 75) op = OP_LOOKUP;
      else if (r < 97) op = OP_DELETE;
      else op = OP_UNUSED;
      if ($urandom_range(99) < 75) key = key_pool[$urandom_range(key_pool.size() - 1)];
      else key = $urandom;
      send_op(op, key, $urandom);
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: extremes, every operation, and a forced eviction chain that runs out.
    send_op(OP_LOOKUP, 32'h0000_0005, 32'h0);
    send_op(OP_DELETE, 32'h0000_0005, 32'h0);
    send_op(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_op(OP_INSERT, 32'h7FFF_FFFF, 32'h0);
    send_op(OP_INSERT, 32'hFFFF_FFFF, 32'hA5A5_5A5A);
    send_op(OP_INSERT, 32'h0000_0000, 32'h1234_5678);
    send_op(OP_INSERT, 32'h8000_0000, 32'h1);
    send_op(OP_LOOKUP, 32'h8000_0000, 32'h0);
    send_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    send_op(OP_UNUSED, 32'h0000_0000, 32'hFFFF_FFFF);
    send_op(OP_DELETE, 32'h7FFF_FFFF, 32'h0);
    send_op(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0);
    send_op(OP_INSERT, 32'd5, 32'd50);
    send_op(OP_INSERT, 32'd13, 32'd130);
    send_op(OP_INSERT, 32'd21, 32'd210);
    send_op(OP_LOOKUP, 32'd21, 32'h0);
    send_op(OP_LOOKUP, 32'd13, 32'h0);
    send_op(OP_DELETE, 32'd21, 32'h0);
    send_op(OP_INSERT, 32'd29, 32'd290);
    send_op(OP_LOOKUP, 32'd5, 32'h0);
    fill_pool(20);
    random_ops(110, -1);
    wait_drained();

    // Random hashes, a small prime, and one long hold-off on the result side.
    write_cfg(REG_MULT1, {$urandom, $urandom});
    write_cfg(REG_ADD1, {$urandom, $urandom});
    write_cfg(REG_MULT2, {$urandom, $urandom});
    write_cfg(REG_ADD2, {$urandom, $urandom});
    write_cfg(REG_PRIME, 64'd13);
    write_cfg(REG_SIZE, 64'd4);
    fill_pool(28);
    random_ops(130, 60);
    wait_drained();

    // Modulus zero, an all-ones first hash, a zero second multiplier, a size below range; no idling on either side.
    idle_on = 0;
    write_cfg(REG_MULT1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(REG_ADD1, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(REG_MULT2, 64'd0);
    write_cfg(REG_PRIME, 64'd0);
    write_cfg(REG_SIZE, 64'd0);
    random_ops(130, -1);
    wait_drained();
    idle_on = 1;

    // Largest 64-bit prime, size above range, wider key pool.
    write_cfg(REG_MULT1, {$urandom, $urandom});
    write_cfg(REG_ADD1, 64'd0);
    write_cfg(REG_MULT2, {$urandom, $urandom});
    write_cfg(REG_ADD2, 64'hFFFF_FFFF_FFFF_FFFF);
    write_cfg(REG_PRIME, 64'hFFFF_FFFF_FFFF_FFC5);
    write_cfg(REG_SIZE, 64'd15);
    fill_pool(120);
    random_ops(160, -1);
    wait_drained();

    if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
